// ----- hw/rtl/assert_macros.svh -----
// assertion macros used by the top-level rtl file
// no dependencies; compiled out when SYNTH is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// same-cycle implication, checked out of reset
`define MPA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// next-cycle implication, checked out of reset
`define MPA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`else

`define MPA_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define MPA_ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ----- hw/rtl/mpa_pkg.sv -----
// constants, types and helpers of the max pooling unit
// no dependencies
package mpa_pkg;

    localparam int MAX_KERNEL   = 8;
    localparam int MAX_WIDTH    = 1024;
    localparam int MAX_HEIGHT   = 1024;
    localparam int MAX_CHANNELS = 1024;

    localparam int PIX_W     = 16;
    localparam int IDX_W     = 30;
    localparam int K_W       = 4;
    localparam int DIM_W     = 11;
    localparam int CFG_IDX_W = 3;

    localparam int COL_W  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int ROW_W  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int CH_W   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int SLOT_W = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;
    localparam int SLOT_CALC_W = K_W + 1;
    localparam int OFF_W  = K_W + DIM_W;

    localparam int ADDR_W      = SLOT_W + COL_W;
    localparam int STORE_DEPTH = MAX_KERNEL * (2 ** COL_W);

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_KERNEL_SIZE  = 3'd0,
        REG_STRIDE       = 3'd1,
        REG_CHANNELS     = 3'd2,
        REG_PLANE_HEIGHT = 3'd3,
        REG_PLANE_WIDTH  = 3'd4
    } cfg_reg_t;

    typedef struct packed {
        logic [K_W-1:0]   k;
        logic [DIM_W-1:0] row_step;
    } scan_cfg_t;

    typedef struct packed {
        logic [SLOT_W-1:0] top_slot;
        logic [COL_W-1:0]  left;
        logic [IDX_W-1:0]  base_idx;
        logic              last;
    } job_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [PIX_W-1:0]  data;
    } store_wr_t;

    typedef struct packed {
        logic busy;
    } back_stat_t;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                   input logic [DIM_W-1:0] max_v);
        logic [DIM_W-1:0] r;
        if (v == '0)
        begin
            r = DIM_W'(1);
        end
        else if (v > max_v)
        begin
            r = max_v;
        end
        else
        begin
            r = v;
        end
        return r;
    endfunction

endpackage

// ----- hw/rtl/mpa_if.sv -----
// stream interfaces of the max pooling unit: pixel words in, pooled words out
// depends on mpa_pkg
interface mpa_pixel_if;
    logic                             valid;
    logic                             ready;
    logic signed [mpa_pkg::PIX_W-1:0] pixel_value;

    modport source (output valid, output pixel_value, input ready);
    modport sink (input valid, input pixel_value, output ready);
endinterface

interface mpa_pool_if;
    logic                             valid;
    logic                             ready;
    logic signed [mpa_pkg::PIX_W-1:0] pooled_value;
    logic [mpa_pkg::IDX_W-1:0]        argmax_index;
    logic                             last_result;

    modport source (output valid, output pooled_value, output argmax_index,
                    output last_result, input ready);
    modport sink (input valid, input pooled_value, input argmax_index,
                  input last_result, output ready);
endinterface

// ----- hw/rtl/mpa_line_store.sv -----
// line store: recent rows of the current plane, one write and one read port
// depends on mpa_pkg; read data registered
module mpa_line_store (
    input  logic                          clk,
    input  mpa_pkg::store_wr_t            wr,
    input  logic [mpa_pkg::ADDR_W-1:0]    rd_addr,
    output logic [mpa_pkg::PIX_W-1:0]     rd_data
);

    logic [mpa_pkg::PIX_W-1:0] mem [mpa_pkg::STORE_DEPTH];
    logic [mpa_pkg::PIX_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- hw/rtl/mpa_job_fifo.sv -----
// short queue of window scan jobs between front and back
// depends on mpa_pkg
module mpa_job_fifo (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  mpa_pkg::job_t push_job,
    input  logic          pop,
    output mpa_pkg::job_t head_job,
    output logic          empty,
    output logic          full
);

    mpa_pkg::job_t                    entries [mpa_pkg::FIFO_DEPTH];
    logic [mpa_pkg::FIFO_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [mpa_pkg::FIFO_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [mpa_pkg::FIFO_PTR_W:0]     count_reg, count_next;

    assign empty    = (count_reg == '0);
    assign full     = (count_reg == (mpa_pkg::FIFO_PTR_W + 1)'(mpa_pkg::FIFO_DEPTH));
    assign head_job = entries[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries[wr_ptr_reg] <= push_job;
        end
    end

endmodule

// ----- hw/rtl/mpa_front.sv -----
// front: config registers, raster position tracking, line store writes
// and detection of window corners; depends on mpa_pkg and mpa_if
module mpa_front (
    input  logic                           clk,
    input  logic                           rst_n,
    mpa_pixel_if.sink                      pixels,
    input  logic                           cfg_write,
    input  logic [mpa_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mpa_pkg::DIM_W-1:0]      cfg_data,
    input  logic                           pending,
    input  logic                           job_full,
    output logic                           job_push,
    output mpa_pkg::job_t                  job,
    output mpa_pkg::store_wr_t             store_wr,
    output mpa_pkg::scan_cfg_t             scan_cfg
);

    logic [mpa_pkg::K_W-1:0]    kernel_reg, kernel_next;
    logic [mpa_pkg::K_W-1:0]    stride_reg, stride_next;
    logic [mpa_pkg::DIM_W-1:0]  channels_reg, channels_next;
    logic [mpa_pkg::DIM_W-1:0]  height_reg, height_next;
    logic [mpa_pkg::DIM_W-1:0]  width_reg, width_next;

    logic [mpa_pkg::COL_W-1:0]  col_reg, col_next;
    logic [mpa_pkg::ROW_W-1:0]  row_reg, row_next;
    logic [mpa_pkg::CH_W-1:0]   ch_reg, ch_next;
    logic [mpa_pkg::SLOT_W-1:0] slot_reg, slot_next;
    logic [mpa_pkg::K_W-1:0]    cph_reg, cph_next;
    logic [mpa_pkg::K_W-1:0]    rph_reg, rph_next;
    logic [mpa_pkg::IDX_W-1:0]  pix_idx_reg, pix_idx_next;

    logic [mpa_pkg::DIM_W-1:0]       cc, hh, ww;
    logic [mpa_pkg::DIM_W-1:0]       x_w, r_w, c_w, km1_w, s_w;
    logic [mpa_pkg::K_W-1:0]         km1, s;
    logic                            k_ok, trig, accept;
    logic                            at_col_end, at_row_end, at_ch_end;
    logic [mpa_pkg::OFF_W-1:0]       win_off;
    logic [mpa_pkg::SLOT_CALC_W-1:0] slot_x, top_x;

    assign cc = mpa_pkg::clamp_dim(channels_reg, mpa_pkg::DIM_W'(mpa_pkg::MAX_CHANNELS));
    assign hh = mpa_pkg::clamp_dim(height_reg, mpa_pkg::DIM_W'(mpa_pkg::MAX_HEIGHT));
    assign ww = mpa_pkg::clamp_dim(width_reg, mpa_pkg::DIM_W'(mpa_pkg::MAX_WIDTH));

    assign km1   = kernel_reg - 1'b1;
    assign s     = (stride_reg != '0) ? stride_reg : kernel_reg;
    assign km1_w = mpa_pkg::DIM_W'(km1);
    assign s_w   = mpa_pkg::DIM_W'(s);
    assign x_w   = mpa_pkg::DIM_W'(col_reg);
    assign r_w   = mpa_pkg::DIM_W'(row_reg);
    assign c_w   = mpa_pkg::DIM_W'(ch_reg);

    assign k_ok = (kernel_reg != '0)
               && (mpa_pkg::DIM_W'(kernel_reg) <= mpa_pkg::DIM_W'(mpa_pkg::MAX_KERNEL))
               && (mpa_pkg::DIM_W'(kernel_reg) <= hh)
               && (mpa_pkg::DIM_W'(kernel_reg) <= ww);

    assign at_col_end = (x_w == ww - 1'b1);
    assign at_row_end = (r_w == hh - 1'b1);
    assign at_ch_end  = (c_w == cc - 1'b1);

    assign trig = k_ok && (x_w >= km1_w) && (r_w >= km1_w)
               && (cph_reg == '0) && (rph_reg == '0);

    // (k-1)*(w+1): offset from the corner pixel back to the window origin
    assign win_off = mpa_pkg::OFF_W'(km1) * mpa_pkg::OFF_W'(ww) + mpa_pkg::OFF_W'(km1);

    assign slot_x = mpa_pkg::SLOT_CALC_W'(slot_reg);
    assign top_x  = (slot_x >= mpa_pkg::SLOT_CALC_W'(km1))
                  ? slot_x - mpa_pkg::SLOT_CALC_W'(km1)
                  : slot_x + mpa_pkg::SLOT_CALC_W'(mpa_pkg::MAX_KERNEL)
                           - mpa_pkg::SLOT_CALC_W'(km1);

    // a new row may overwrite rows that queued scans still read
    assign pixels.ready = !job_full && !((col_reg == '0) && pending);
    assign accept       = pixels.valid && pixels.ready;

    assign job_push     = accept && trig;
    assign job.top_slot = mpa_pkg::SLOT_W'(top_x);
    assign job.left     = col_reg - mpa_pkg::COL_W'(km1);
    assign job.base_idx = pix_idx_reg - mpa_pkg::IDX_W'(win_off);
    assign job.last     = at_ch_end && ((r_w + s_w) >= hh) && ((x_w + s_w) >= ww);

    assign store_wr.en   = accept;
    assign store_wr.addr = {slot_reg, col_reg};
    assign store_wr.data = pixels.pixel_value;

    assign scan_cfg.k        = kernel_reg;
    assign scan_cfg.row_step = ww - km1_w;

    always_comb
    begin
        kernel_next   = kernel_reg;
        stride_next   = stride_reg;
        channels_next = channels_reg;
        height_next   = height_reg;
        width_next    = width_reg;
        col_next      = col_reg;
        row_next      = row_reg;
        ch_next       = ch_reg;
        slot_next     = slot_reg;
        cph_next      = cph_reg;
        rph_next      = rph_reg;
        pix_idx_next  = pix_idx_reg;

        if (cfg_write)
        begin
            case (cfg_index)
                mpa_pkg::REG_KERNEL_SIZE:  kernel_next   = cfg_data[mpa_pkg::K_W-1:0];
                mpa_pkg::REG_STRIDE:       stride_next   = cfg_data[mpa_pkg::K_W-1:0];
                mpa_pkg::REG_CHANNELS:     channels_next = cfg_data;
                mpa_pkg::REG_PLANE_HEIGHT: height_next   = cfg_data;
                mpa_pkg::REG_PLANE_WIDTH:  width_next    = cfg_data;
                default:                   ;
            endcase
            col_next     = '0;
            row_next     = '0;
            ch_next      = '0;
            slot_next    = '0;
            cph_next     = '0;
            rph_next     = '0;
            pix_idx_next = '0;
        end
        else if (accept)
        begin
            pix_idx_next = (at_col_end && at_row_end && at_ch_end) ? '0 : pix_idx_reg + 1'b1;
            if (at_col_end)
            begin
                col_next = '0;
                cph_next = '0;
                if (at_row_end)
                begin
                    row_next  = '0;
                    slot_next = '0;
                    rph_next  = '0;
                    ch_next   = at_ch_end ? '0 : ch_reg + 1'b1;
                end
                else
                begin
                    row_next  = row_reg + 1'b1;
                    slot_next = (slot_reg == mpa_pkg::SLOT_W'(mpa_pkg::MAX_KERNEL - 1))
                              ? '0 : slot_reg + 1'b1;
                    if (r_w >= km1_w)
                    begin
                        rph_next = (rph_reg == '0) ? s - 1'b1 : rph_reg - 1'b1;
                    end
                end
            end
            else
            begin
                col_next = col_reg + 1'b1;
                if (x_w >= km1_w)
                begin
                    cph_next = (cph_reg == '0) ? s - 1'b1 : cph_reg - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kernel_reg   <= mpa_pkg::K_W'(2);
            stride_reg   <= '0;
            channels_reg <= mpa_pkg::DIM_W'(1);
            height_reg   <= mpa_pkg::DIM_W'(1);
            width_reg    <= mpa_pkg::DIM_W'(1);
            col_reg      <= '0;
            row_reg      <= '0;
            ch_reg       <= '0;
            slot_reg     <= '0;
            cph_reg      <= '0;
            rph_reg      <= '0;
            pix_idx_reg  <= '0;
        end
        else
        begin
            kernel_reg   <= kernel_next;
            stride_reg   <= stride_next;
            channels_reg <= channels_next;
            height_reg   <= height_next;
            width_reg    <= width_next;
            col_reg      <= col_next;
            row_reg      <= row_next;
            ch_reg       <= ch_next;
            slot_reg     <= slot_next;
            cph_reg      <= cph_next;
            rph_reg      <= rph_next;
            pix_idx_reg  <= pix_idx_next;
        end
    end

endmodule

// ----- hw/rtl/mpa_back.sv -----
// back: scans one window per job through the line store read port and
// keeps the running maximum; depends on mpa_pkg and mpa_if
module mpa_back (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         job_empty,
    input  mpa_pkg::job_t                job,
    output logic                         job_pop,
    input  mpa_pkg::scan_cfg_t           scan_cfg,
    output logic [mpa_pkg::ADDR_W-1:0]   rd_addr,
    input  logic [mpa_pkg::PIX_W-1:0]    rd_data,
    mpa_pool_if.source                   pooled,
    output mpa_pkg::back_stat_t          stat
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_SCAN = 4'b0010,
        ST_WAIT = 4'b0100,
        ST_HOLD = 4'b1000
    } back_state_t;

    back_state_t state_reg, state_next;

    logic [mpa_pkg::SLOT_W-1:0] slot_reg, slot_next;
    logic [mpa_pkg::COL_W-1:0]  col_reg, col_next;
    logic [mpa_pkg::COL_W-1:0]  left_reg, left_next;
    logic [mpa_pkg::K_W-1:0]    kh_reg, kh_next;
    logic [mpa_pkg::K_W-1:0]    kw_reg, kw_next;
    logic [mpa_pkg::IDX_W-1:0]  idx_a_reg, idx_a_next;
    logic                       last_reg, last_next;

    logic                       rd_vld_reg, rd_vld_next;
    logic                       first_b_reg, first_b_next;
    logic [mpa_pkg::IDX_W-1:0]  idx_b_reg, idx_b_next;

    logic [mpa_pkg::PIX_W-1:0]  best_reg, best_next;
    logic [mpa_pkg::IDX_W-1:0]  best_idx_reg, best_idx_next;

    logic                       out_vld_reg, out_vld_next;
    logic [mpa_pkg::PIX_W-1:0]  out_val_reg, out_val_next;
    logic [mpa_pkg::IDX_W-1:0]  out_idx_reg, out_idx_next;
    logic                       out_last_reg, out_last_next;

    logic [mpa_pkg::K_W-1:0] km1;
    logic                    take, row_done, out_free;

    assign km1      = scan_cfg.k - 1'b1;
    assign row_done = (kw_reg == km1);
    assign take     = rd_vld_reg && (first_b_reg || ($signed(rd_data) > $signed(best_reg)));
    assign out_free = !out_vld_reg || pooled.ready;

    assign job_pop   = (state_reg == ST_IDLE) && !job_empty;
    assign rd_addr   = {slot_reg, col_reg};
    assign stat.busy = (state_reg != ST_IDLE);

    assign pooled.valid        = out_vld_reg;
    assign pooled.pooled_value = out_val_reg;
    assign pooled.argmax_index = out_idx_reg;
    assign pooled.last_result  = out_last_reg;

    always_comb
    begin
        state_next    = state_reg;
        slot_next     = slot_reg;
        col_next      = col_reg;
        left_next     = left_reg;
        kh_next       = kh_reg;
        kw_next       = kw_reg;
        idx_a_next    = idx_a_reg;
        last_next     = last_reg;
        rd_vld_next   = 1'b0;
        first_b_next  = first_b_reg;
        idx_b_next    = idx_b_reg;
        best_next     = best_reg;
        best_idx_next = best_idx_reg;
        out_vld_next  = out_vld_reg && !pooled.ready;
        out_val_next  = out_val_reg;
        out_idx_next  = out_idx_reg;
        out_last_next = out_last_reg;

        // compare stage, in the cycle after the read issue
        if (take)
        begin
            best_next     = rd_data;
            best_idx_next = idx_b_reg;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (!job_empty)
                begin
                    slot_next  = job.top_slot;
                    col_next   = job.left;
                    left_next  = job.left;
                    idx_a_next = job.base_idx;
                    last_next  = job.last;
                    kh_next    = '0;
                    kw_next    = '0;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                rd_vld_next  = 1'b1;
                first_b_next = (kh_reg == '0) && (kw_reg == '0);
                idx_b_next   = idx_a_reg;
                if (row_done)
                begin
                    kw_next    = '0;
                    col_next   = left_reg;
                    kh_next    = kh_reg + 1'b1;
                    slot_next  = (slot_reg == mpa_pkg::SLOT_W'(mpa_pkg::MAX_KERNEL - 1))
                               ? '0 : slot_reg + 1'b1;
                    idx_a_next = idx_a_reg + mpa_pkg::IDX_W'(scan_cfg.row_step);
                    if (kh_reg == km1)
                    begin
                        state_next = ST_WAIT;
                    end
                end
                else
                begin
                    kw_next    = kw_reg + 1'b1;
                    col_next   = col_reg + 1'b1;
                    idx_a_next = idx_a_reg + 1'b1;
                end
            end
            ST_WAIT:
            begin
                state_next = ST_HOLD;
            end
            ST_HOLD:
            begin
                if (out_free)
                begin
                    out_vld_next  = 1'b1;
                    out_val_next  = best_reg;
                    out_idx_next  = best_idx_reg;
                    out_last_next = last_reg;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            rd_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            rd_vld_reg  <= rd_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot_reg     <= slot_next;
        col_reg      <= col_next;
        left_reg     <= left_next;
        kh_reg       <= kh_next;
        kw_reg       <= kw_next;
        idx_a_reg    <= idx_a_next;
        last_reg     <= last_next;
        first_b_reg  <= first_b_next;
        idx_b_reg    <= idx_b_next;
        best_reg     <= best_next;
        best_idx_reg <= best_idx_next;
        out_val_reg  <= out_val_next;
        out_idx_reg  <= out_idx_next;
        out_last_reg <= out_last_next;
    end

endmodule

// ----- hw/rtl/max_pool_2d_with_argmax_unit.sv -----
// streaming 2-d max pooling with argmax over one chw tensor: pixel words enter in
// raster order and are written to an 8-row line store of 8192 x 16 bits that needs
// no clearing pass after reset; a pixel that closes a window on the stride grid
// queues a scan job (queue of four) and the back end reads that window through the
// single store read port, one element per cycle; the window maximum then passes
// through a wait and a hold state and is registered at the output once the output
// register is free; a pixel is taken each cycle while the queue has room, but the
// first pixel of a row waits until every queued scan has finished; any register
// write restarts the tensor position at zero
// depends on mpa_pkg, mpa_if, mpa_line_store, mpa_job_fifo, mpa_front, mpa_back
`include "assert_macros.svh"

module max_pool_2d_with_argmax_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    mpa_pixel_if.sink                     pixels,
    mpa_pool_if.source                    pooled,
    input  logic                          cfg_write,
    input  logic [mpa_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [mpa_pkg::DIM_W-1:0]     cfg_data
);

    mpa_pkg::job_t              push_job, head_job;
    mpa_pkg::store_wr_t         store_wr;
    mpa_pkg::scan_cfg_t         scan_cfg;
    mpa_pkg::back_stat_t        back_stat;
    logic                       job_push, job_pop, job_empty, job_full, pending;
    logic [mpa_pkg::ADDR_W-1:0] rd_addr;
    logic [mpa_pkg::PIX_W-1:0]  rd_data;

    assign pending = !job_empty || back_stat.busy;

    mpa_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .pixels   (pixels),
        .cfg_write(cfg_write),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .pending  (pending),
        .job_full (job_full),
        .job_push (job_push),
        .job      (push_job),
        .store_wr (store_wr),
        .scan_cfg (scan_cfg)
    );

    mpa_job_fifo u_job_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (job_push),
        .push_job(push_job),
        .pop     (job_pop),
        .head_job(head_job),
        .empty   (job_empty),
        .full    (job_full)
    );

    mpa_line_store u_line_store (
        .clk    (clk),
        .wr     (store_wr),
        .rd_addr(rd_addr),
        .rd_data(rd_data)
    );

    mpa_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .job_empty(job_empty),
        .job      (head_job),
        .job_pop  (job_pop),
        .scan_cfg (scan_cfg),
        .rd_addr  (rd_addr),
        .rd_data  (rd_data),
        .pooled   (pooled),
        .stat     (back_stat)
    );

    `MPA_ASSERT_IMP(a_no_push_when_full, clk, rst_n, job_push, !job_full)
    `MPA_ASSERT_NXT(a_push_fills_queue, clk, rst_n, job_push && !job_pop, !job_empty)
    `MPA_ASSERT_IMP(a_pop_only_when_idle, clk, rst_n, job_pop, !back_stat.busy && !job_empty)

endmodule
